@@ design/bclru_pkg.sv @@
// shared constants and types for the write-back block cache tag store
`default_nettype none

package bclru_pkg;

    localparam int unsigned ENTRIES = 64;
    localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned BLK_W   = 32;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned OUT_W   = 48;

    // access kind on the tuser bit and status bit of the result
    localparam logic OP_WRITE       = 1'b1;
    localparam logic STAT_BAD_BLOCK = 1'b1;

    typedef struct packed {
        logic [BLK_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
        logic               dirty;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_zero;
        logic cmp_hit;
        logic cmp_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ design/bclru_ctrl.sv @@
// sequencer for one cache access: accept, scan the tag store, commit
`default_nettype none

module bclru_ctrl
    import bclru_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                // block zero leaves the scan without comparing any entry
                if (status.req_zero || status.cmp_hit || status.cmp_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == ST_IDLE)
        else $error("commit did not return to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_SCAN)
        else $error("accepted transaction did not start a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.commit}))
        else $error("overlapping controller commands");

endmodule

`default_nettype wire

@@ design/bclru_dp.sv @@
// tag store, lru scan registers, use counter and result register
`default_nettype none

module bclru_dp
    import bclru_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_cmd_t         cmd,
    output dp_status_t             status,
    input  wire logic [BLK_W-1:0]  s_tdata,
    input  wire logic [0:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata
);

    entry_t                mem [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;

    logic [BLK_W-1:0]      blk_reg;
    logic                  wr_reg;
    logic                  req_zero_reg;

    logic [IDX_W-1:0]      rd_idx_reg;
    entry_t                rd_data_reg;
    logic                  rd_valid_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  cmp_valid_reg;

    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic                  hit_dirty_reg;
    logic [STAMP_W-1:0]    best_reg;
    logic [IDX_W-1:0]      vic_idx_reg;
    logic [BLK_W-1:0]      vic_tag_reg;
    logic                  vic_dirty_reg;

    logic [STAMP_W-1:0]    use_cnt_reg;

    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;

    entry_t                cur;
    logic                  cmp_en;
    logic                  take_min;
    logic [IDX_W-1:0]      wr_idx;
    entry_t                wr_word;
    logic                  wb_need;
    logic [OUT_W-1:0]      out_word;

    // never-written entries read as the reset value
    assign cur      = rd_valid_reg ? rd_data_reg : entry_t'('0);
    assign cmp_en   = cmd.scan && cmp_valid_reg && !hit_reg;
    assign take_min = (cur.stamp < best_reg) || (cmp_idx_reg == '0);

    assign status.req_zero = req_zero_reg;
    assign status.cmp_hit  = cmp_en && (cur.tag == blk_reg);
    assign status.cmp_last = cmp_en && (cmp_idx_reg == IDX_W'(ENTRIES - 1));
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign wr_idx        = hit_reg ? hit_idx_reg : vic_idx_reg;
    assign wr_word.tag   = blk_reg;
    assign wr_word.stamp = use_cnt_reg;
    assign wr_word.dirty = hit_reg ? (hit_dirty_reg | wr_reg) : wr_reg;
    assign wb_need       = !hit_reg && vic_dirty_reg;

    always_comb
    begin
        out_word = '0;
        if (req_zero_reg)
        begin
            out_word[0] = STAT_BAD_BLOCK;
        end
        else
        begin
            out_word[1]    = hit_reg;
            out_word[7:2]  = SLOT_W'(wr_idx);
            out_word[8]    = wb_need;
            out_word[40:9] = wb_need ? vic_tag_reg : '0;
            out_word[41]   = !hit_reg && !wr_reg;
        end
    end

    // tag store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !req_zero_reg)
        begin
            mem[wr_idx] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            use_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            req_zero_reg  <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan;
            if (cmd.load)
            begin
                rd_idx_reg   <= '0;
                hit_reg      <= 1'b0;
                req_zero_reg <= (s_tdata == '0);
            end
            else if (cmd.scan)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (status.cmp_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.commit && !req_zero_reg)
            begin
                valid_reg[wr_idx] <= 1'b1;
                use_cnt_reg       <= use_cnt_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            blk_reg  <= s_tdata;
            wr_reg   <= (s_tuser[0] == OP_WRITE);
            best_reg <= '1;
        end
        if (cmd.scan)
        begin
            rd_valid_reg <= valid_reg[rd_idx_reg];
            cmp_idx_reg  <= rd_idx_reg;
        end
        if (status.cmp_hit)
        begin
            hit_idx_reg   <= cmp_idx_reg;
            hit_dirty_reg <= cur.dirty;
        end
        // first entry always seeds the victim so a full-stamp store evicts entry zero
        if (cmp_en && take_min)
        begin
            best_reg      <= cur.stamp;
            vic_idx_reg   <= cmp_idx_reg;
            vic_tag_reg   <= cur.tag;
            vic_dirty_reg <= cur.dirty;
        end
        if (cmd.commit)
        begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && !req_zero_reg |=> use_cnt_reg == $past(use_cnt_reg) + 1'b1)
        else $error("use counter did not advance on a successful access");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && req_zero_reg |=> $stable(use_cnt_reg) && $stable(valid_reg))
        else $error("rejected access changed state");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_tdata_reg[0] |-> m_tdata_reg[OUT_W-1:1] == '0)
        else $error("error result carries non-zero fields");

endmodule

`default_nettype wire

@@ design/block_cache_lru_writeback.sv @@
// top level of the fully associative write-back block cache tag store
`default_nettype none

// Tag and control store of a 64-entry fully associative write-back block
// cache with least-recently-used replacement. One transaction is taken at a
// time on the s_ side and one result is returned per transaction on the m_
// side; the result sits in an output register, so the next transaction is
// taken while it waits. The tag store has one write port and one read port
// and is scanned one entry per cycle; a miss scans every entry, a hit stops
// at the matching entry, and a request for block zero compares no entry.
// The store comes out of reset empty with no clearing pass.
module block_cache_lru_writeback
    import bclru_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BLK_W-1:0]  s_tdata,   // [31:0] block_number
    input  wire logic [0:0]        s_tuser,   // [0] cmd (0 read, 1 write)
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata    // [0] status, [1] hit, [7:2] slot,
                                              // [8] writeback_needed,
                                              // [40:9] writeback_block,
                                              // [41] fill_needed, [47:42] zero
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bclru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bclru_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ dv/bclru_tb_pkg.sv @@
// access and status codes shared by the cache tag store testbench files

package bclru_tb_pkg;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cache_cmd_e;

    typedef enum logic {
        STATUS_OK        = 1'b0,
        STATUS_BAD_BLOCK = 1'b1
    } access_status_e;

endpackage

@@ dv/bclru_tag_checker.sv @@
// checker that mirrors the lru tag store and compares every returned result

module bclru_tag_checker
    import bclru_pkg::*;
    import bclru_tb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    input  wire logic             s_tready,
    input  wire logic [BLK_W-1:0] s_tdata,   // [31:0] block_number
    input  wire logic [0:0]       s_tuser,   // [0] cmd
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [OUT_W-1:0] m_tdata,   // [0] status, [1] hit, [7:2] slot,
                                             // [8] writeback_needed,
                                             // [40:9] writeback_block,
                                             // [41] fill_needed, [47:42] zero
    output int unsigned           mismatches,
    output int unsigned           pending
);

    typedef struct packed {
        logic              status;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              wb_needed;
        logic [BLK_W-1:0]  wb_block;
        logic              fill_needed;
    } access_result_t;

    logic [BLK_W-1:0]   tag_mem   [ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [ENTRIES];
    logic               dirty_mem [ENTRIES];
    logic [STAMP_W-1:0] use_count;

    access_result_t expected_results [$];

    function automatic access_result_t predict_access(cache_cmd_e cmd, logic [BLK_W-1:0] blk);
        access_result_t res;
        logic [STAMP_W-1:0] best;
        int unsigned victim;
        int hit_idx;
        res = '0;
        if (blk == '0)
        begin
            res.status = STATUS_BAD_BLOCK;
            return res;
        end
        best    = '1;
        victim  = 0;
        hit_idx = -1;
        // first entry with the smallest stamp wins, entry 0 if none is below all-ones
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_idx < 0)
            begin
                if (tag_mem[i] == blk)
                    hit_idx = i;
                else if (stamp_mem[i] < best)
                begin
                    best   = stamp_mem[i];
                    victim = i;
                end
            end
        end
        if (hit_idx >= 0)
        begin
            stamp_mem[hit_idx] = use_count;
            use_count          = use_count + 1'b1;
            if (cmd == CMD_WRITE)
                dirty_mem[hit_idx] = 1'b1;
            res.hit  = 1'b1;
            res.slot = SLOT_W'(hit_idx);
        end
        else
        begin
            if (dirty_mem[victim])
            begin
                res.wb_needed = 1'b1;
                res.wb_block  = tag_mem[victim];
            end
            res.slot          = SLOT_W'(victim);
            res.fill_needed   = (cmd == CMD_READ);
            tag_mem[victim]   = blk;
            stamp_mem[victim] = use_count;
            use_count         = use_count + 1'b1;
            dirty_mem[victim] = (cmd == CMD_WRITE);
        end
        return res;
    endfunction

    function automatic int unsigned field_bad(string name, logic [BLK_W-1:0] exp_val,
                                              logic [BLK_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        access_result_t exp_res;
        int unsigned bad;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_mem[i]   = '0;
                stamp_mem[i] = '0;
                dirty_mem[i] = 1'b0;
            end
            use_count = '0;
            expected_results.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            bad = 0;
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no expected result pending");
                    bad++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    bad += field_bad("status", exp_res.status, m_tdata[0]);
                    bad += field_bad("hit", exp_res.hit, m_tdata[1]);
                    bad += field_bad("slot", exp_res.slot, m_tdata[7:2]);
                    bad += field_bad("writeback_needed", exp_res.wb_needed, m_tdata[8]);
                    bad += field_bad("writeback_block", exp_res.wb_block, m_tdata[40:9]);
                    bad += field_bad("fill_needed", exp_res.fill_needed, m_tdata[41]);
                    bad += field_bad("padding", '0, m_tdata[47:42]);
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_access(cache_cmd_e'(s_tuser[0]), s_tdata));
            mismatches <= mismatches + bad;
            pending    <= expected_results.size();
        end
    end

endmodule

@@ dv/tb_block_cache_lru_writeback.sv @@
// testbench top: drives block accesses into the lru tag store and gives the verdict

module tb_block_cache_lru_writeback;

    import bclru_pkg::*;
    import bclru_tb_pkg::*;

    localparam int unsigned RANDOM_ACCESSES = 1300;
    localparam int unsigned POOL_SIZE       = 96;
    localparam int unsigned HOT_SIZE        = 24;
    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned DRAIN_CYCLES    = 80;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [BLK_W-1:0] s_tdata  = '0;   // [31:0] block_number
    logic [0:0]       s_tuser  = '0;   // [0] cmd
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // [0] status, [1] hit, [7:2] slot,
                                       // [8] writeback_needed, [40:9] writeback_block,
                                       // [41] fill_needed, [47:42] zero

    int unsigned mismatches;
    int unsigned pending;
    int unsigned idle_cycles = 0;
    int unsigned ready_hold  = 0;
    int unsigned burst_left  = 0;

    logic [BLK_W-1:0] block_pool [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    block_cache_lru_writeback u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bclru_tag_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // result side back-pressure: short stalls, a few long ones, some long ready stretches
    always @(posedge clk)
    begin : ready_gen
        int unsigned r;
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 15);
            end
            else if (r < 65)
            begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(150, 300);
            end
            else if (r < 95)
            begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end
            else
            begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left != 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r == 0)
        begin
            burst_left = $urandom_range(30, 60);
            return 0;
        end
        if (r < 100)
            return 0;
        if (r < 170)
            return $urandom_range(1, 3);
        if (r < 194)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BLK_W-1:0] nonzero_block();
        logic [BLK_W-1:0] b;
        b = $urandom;
        return (b == '0) ? BLK_W'(1) : b;
    endfunction

    // valid stays high across back-to-back transactions, lowered only for a gap
    task automatic send_access(cache_cmd_e cmd, logic [BLK_W-1:0] blk);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    initial
    begin : stimulus
        int unsigned r;
        int unsigned idx;
        logic [BLK_W-1:0] blk;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bad block number on both access kinds, then hits and misses on field extremes
        send_access(CMD_READ, '0);
        send_access(CMD_WRITE, '0);
        send_access(CMD_READ, 32'h0000_0001);
        send_access(CMD_READ, 32'h0000_0001);
        send_access(CMD_WRITE, 32'h0000_0001);
        send_access(CMD_WRITE, 32'hFFFF_FFFF);
        send_access(CMD_READ, 32'hFFFF_FFFF);
        send_access(CMD_WRITE, 32'hFFFF_FFFF);
        send_access(CMD_WRITE, 32'h8000_0000);
        send_access(CMD_READ, 32'h7FFF_FFFF);
        send_access(CMD_READ, 32'h5555_5555);
        send_access(CMD_WRITE, 32'hAAAA_AAAA);
        send_access(CMD_READ, '0);
        send_access(CMD_READ, 32'h0000_0001);
        send_access(CMD_READ, 32'hAAAA_AAAA);
        send_access(CMD_WRITE, 32'h5555_5555);
        send_access(CMD_WRITE, '0);
        send_access(CMD_READ, 32'h8000_0000);

        for (int i = 0; i < POOL_SIZE; i++)
            block_pool[i] = nonzero_block();
        block_pool[0] = 32'hFFFF_FFFF;
        block_pool[1] = 32'h0000_0001;

        // a hot set that fits the store for hits, the whole pool for dirty evictions
        for (int n = 0; n < RANDOM_ACCESSES; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                blk = '0;
            else if (r < 14)
                blk = $urandom;
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    idx = $urandom_range(0, POOL_SIZE - 1);
                else
                    idx = $urandom_range(0, HOT_SIZE - 1);
                blk = block_pool[idx];
            end
            if ($urandom_range(0, 49) == 0)
                block_pool[$urandom_range(0, POOL_SIZE - 1)] = nonzero_block();
            send_access(cache_cmd_e'($urandom_range(0, 1)), blk);
        end
        s_tvalid <= 1'b0;

        // let the checker count the last accepted transaction first
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
